// ===== rtl/pid_controller_anti_windup_unit_defines.svh =====
// ----------------------------------------------------------------------------
// PID controller assertion macros
// Shared property templates for the checker; clock aclk, reset aresetn.
// ----------------------------------------------------------------------------
`ifndef PID_CONTROLLER_ANTI_WINDUP_UNIT_DEFINES_SVH
`define PID_CONTROLLER_ANTI_WINDUP_UNIT_DEFINES_SVH

// same-cycle implication
`define PCAW_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PCAW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/pcaw_pkg.sv =====
// ----------------------------------------------------------------------------
// PID controller package
// Microcode format, step names, register indexes and shared constants.
// ----------------------------------------------------------------------------
package pcaw_pkg;

    localparam int unsigned STEP_W    = 4;
    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [31:0] LO_BOUND_RST = 32'h8000_0000;
    localparam logic [31:0] HI_BOUND_RST = 32'h7FFF_FFFF;
    localparam logic [31:0] PERIOD_RST   = 32'h0001_0000;

    localparam logic [CFG_IDX_W-1:0] REG_KP  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KI  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KD  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LO  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HI  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PER = 3'd5;

    localparam logic [1:0] LIMIT_NONE = 2'd0;
    localparam logic [1:0] LIMIT_HIGH = 2'd1;
    localparam logic [1:0] LIMIT_LOW  = 2'd2;

    localparam logic [STEP_W-1:0] ST_IDLE     = 4'd0;
    localparam logic [STEP_W-1:0] ST_DIFF     = 4'd1;
    localparam logic [STEP_W-1:0] ST_MUL_KD   = 4'd2;
    localparam logic [STEP_W-1:0] ST_DIV_GO   = 4'd3;
    localparam logic [STEP_W-1:0] ST_FLOOR_I  = 4'd4;
    localparam logic [STEP_W-1:0] ST_MUL_HI   = 4'd5;
    localparam logic [STEP_W-1:0] ST_ACC_HI   = 4'd6;
    localparam logic [STEP_W-1:0] ST_ACC_LO   = 4'd7;
    localparam logic [STEP_W-1:0] ST_SAT_I    = 4'd8;
    localparam logic [STEP_W-1:0] ST_ACC_P    = 4'd9;
    localparam logic [STEP_W-1:0] ST_DIV_WAIT = 4'd10;
    localparam logic [STEP_W-1:0] ST_ACC_D    = 4'd11;
    localparam logic [STEP_W-1:0] ST_OUT_WAIT = 4'd12;
    localparam logic [STEP_W-1:0] ST_FINISH   = 4'd13;
    localparam logic [STEP_W-1:0] ST_CLEAR    = 4'd14;

    typedef enum logic [2:0] {
        MUL_ERR_KP,
        MUL_ERR_KI,
        MUL_KD_DELTA,
        MUL_F1HI_PER,
        MUL_F1LO_PER
    } mul_sel_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_CAPTURE,
        OP_DIFFS,
        OP_TMP_FLOOR,
        OP_ACC_INTEG_PROD,
        OP_ACC_ADD_PROD_SH,
        OP_INTEG_SAT,
        OP_ACC_P_INTEG,
        OP_ACC_ADD_DERIV,
        OP_FINISH,
        OP_CLEAR
    } dp_op_t;

    typedef enum logic [2:0] {
        COND_NEXT,
        COND_ALWAYS,
        COND_NO_START,
        COND_CLEAR,
        COND_DIV_BUSY,
        COND_OUT_BUSY
    } cond_t;

    typedef struct packed {
        dp_op_t             op;
        mul_sel_t           mul_sel;
        logic               mul_en;
        logic               div_start;
        logic               in_ready;
        cond_t              cond;
        logic [STEP_W-1:0]  target;
    } ctrl_t;

    typedef struct packed {
        logic start;
        logic clear;
        logic div_busy;
        logic out_busy;
    } status_t;

    function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
        ctrl_t w;
        w           = '0;
        w.op        = OP_NOP;
        w.mul_sel   = MUL_ERR_KP;
        w.cond      = COND_NEXT;
        w.target    = ST_IDLE;
        case (step)
            ST_IDLE: begin
                w.op       = OP_CAPTURE;
                w.in_ready = 1'b1;
                w.cond     = COND_NO_START;
                w.target   = ST_IDLE;
            end
            ST_DIFF: begin
                w.op     = OP_DIFFS;
                w.cond   = COND_CLEAR;
                w.target = ST_CLEAR;
            end
            ST_MUL_KD: begin
                w.mul_sel = MUL_KD_DELTA;
                w.mul_en  = 1'b1;
            end
            ST_DIV_GO: begin
                w.div_start = 1'b1;
                w.mul_sel   = MUL_ERR_KI;
                w.mul_en    = 1'b1;
            end
            ST_FLOOR_I: begin
                w.op = OP_TMP_FLOOR;
            end
            ST_MUL_HI: begin
                w.mul_sel = MUL_F1HI_PER;
                w.mul_en  = 1'b1;
            end
            ST_ACC_HI: begin
                w.op      = OP_ACC_INTEG_PROD;
                w.mul_sel = MUL_F1LO_PER;
                w.mul_en  = 1'b1;
            end
            ST_ACC_LO: begin
                w.op      = OP_ACC_ADD_PROD_SH;
                w.mul_sel = MUL_ERR_KP;
                w.mul_en  = 1'b1;
            end
            ST_SAT_I: begin
                w.op = OP_INTEG_SAT;
            end
            ST_ACC_P: begin
                w.op = OP_ACC_P_INTEG;
            end
            ST_DIV_WAIT: begin
                w.cond   = COND_DIV_BUSY;
                w.target = ST_DIV_WAIT;
            end
            ST_ACC_D: begin
                w.op = OP_ACC_ADD_DERIV;
            end
            ST_OUT_WAIT: begin
                w.cond   = COND_OUT_BUSY;
                w.target = ST_OUT_WAIT;
            end
            ST_FINISH: begin
                w.op     = OP_FINISH;
                w.cond   = COND_ALWAYS;
                w.target = ST_IDLE;
            end
            ST_CLEAR: begin
                w.op     = OP_CLEAR;
                w.cond   = COND_ALWAYS;
                w.target = ST_IDLE;
            end
            default: begin
                w.cond   = COND_ALWAYS;
                w.target = ST_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/pcaw_mul.sv =====
// ----------------------------------------------------------------------------
// PID controller multiplier
// Signed 33 x 33 multiplier with a registered product and load enable.
// ----------------------------------------------------------------------------
module pcaw_mul (
    input  logic                aclk,
    input  logic                en,
    input  logic signed [32:0]  a,
    input  logic signed [32:0]  b,
    output logic signed [65:0]  p
);

    logic signed [65:0] p_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg <= a * b;
        end
    end

    assign p = p_reg;

endmodule

// ===== rtl/pcaw_div.sv =====
// ----------------------------------------------------------------------------
// PID controller divider
// Unsigned 64 / 32 restoring divider, two quotient bits per cycle.
// ----------------------------------------------------------------------------
module pcaw_div (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [63:0]  dividend,
    input  logic [31:0]  divisor,
    output logic         busy,
    output logic [63:0]  quotient
);

    localparam int unsigned DIV_STEPS = 32;
    localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

    logic                  busy_reg;
    logic [DIV_CNT_W-1:0]  cnt_reg;
    logic [31:0]           rem_reg;
    logic [31:0]           den_reg;
    logic [63:0]           quo_reg;

    logic [32:0]  r1;
    logic [32:0]  r2;
    logic         ge1;
    logic         ge2;
    logic [32:0]  r1_sub;
    logic [32:0]  r2_sub;
    logic [31:0]  rem1;
    logic [31:0]  rem2;

    always_comb begin
        r1     = {rem_reg, quo_reg[63]};
        ge1    = r1 >= {1'b0, den_reg};
        r1_sub = r1 - {1'b0, den_reg};
        rem1   = ge1 ? r1_sub[31:0] : r1[31:0];
        r2     = {rem1, quo_reg[62]};
        ge2    = r2 >= {1'b0, den_reg};
        r2_sub = r2 - {1'b0, den_reg};
        rem2   = ge2 ? r2_sub[31:0] : r2[31:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            cnt_reg <= DIV_CNT_W'(cnt_reg + 1'b1);
            if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            den_reg <= divisor;
            quo_reg <= dividend;
        end else if (busy_reg) begin
            rem_reg <= rem2;
            quo_reg <= {quo_reg[61:0], ge1, ge2};
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

// ===== rtl/pcaw_seq.sv =====
// ----------------------------------------------------------------------------
// PID controller sequencer
// Step counter over the microcode table with conditional jumps.
// ----------------------------------------------------------------------------
module pcaw_seq
    import pcaw_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  status_t  status,
    output ctrl_t    ctrl
);

    logic [STEP_W-1:0]  pc_reg;
    logic [STEP_W-1:0]  pc_next;
    logic               take;

    assign ctrl = ucode(pc_reg);

    always_comb begin
        case (ctrl.cond)
            COND_NEXT:     take = 1'b0;
            COND_ALWAYS:   take = 1'b1;
            COND_NO_START: take = !status.start;
            COND_CLEAR:    take = status.clear;
            COND_DIV_BUSY: take = status.div_busy;
            COND_OUT_BUSY: take = status.out_busy;
            default:       take = 1'b1;
        endcase
        pc_next = take ? ctrl.target : STEP_W'(pc_reg + 1'b1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= ST_IDLE;
        end else begin
            pc_reg <= pc_next;
        end
    end

endmodule

// ===== rtl/pid_controller_anti_windup_unit.sv =====
// ----------------------------------------------------------------------------
// PID controller with anti-windup
// Fixed-point Q16.16 PID step, derivative on measurement, clamped output.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel carries one request per control update: s_tdata holds
//   setpoint and measurement, s_tuser the action (0 update, 1 clear state).
//   m_ channel returns drive in m_tdata and the clamp code in m_tuser.
//   A clear request produces no result.
//   Gains, bounds and sample period are loaded through cfg_we/cfg_index/
//   cfg_wdata while the unit is idle.
// Timing:
//   One request at a time. The time from accept to result valid is set by
//   the radix-4 divider that forms the derivative term; the multiply steps
//   overlap with it. s_tready returns in the cycle the result is loaded.
// Reset:
//   aresetn (synchronous) clears the integral, previous measurement and
//   the output valid, and restores register defaults.
// Stall:
//   The result is held in the output register; while m_tready is low the
//   sequencer parks before writing the next result.
// ----------------------------------------------------------------------------
module pid_controller_anti_windup_unit
    import pcaw_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [63:0]           s_tdata,   // [31:0] setpoint, [63:32] measurement
    input  logic                  s_tuser,   // [0] action
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [31:0]           m_tdata,   // [31:0] drive
    output logic [1:0]            m_tuser,   // [1:0] limit_hit
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [31:0]           cfg_wdata
);

    ctrl_t    ctrl;
    status_t  status;

    logic signed [31:0]  kp_reg;
    logic signed [31:0]  ki_reg;
    logic signed [31:0]  kd_reg;
    logic signed [31:0]  lo_reg;
    logic signed [31:0]  hi_reg;
    logic [31:0]         per_reg;

    logic signed [31:0]  sp_reg,    sp_next;
    logic signed [31:0]  ms_reg,    ms_next;
    logic                act_reg,   act_next;
    logic signed [32:0]  err_reg,   err_next;
    logic signed [32:0]  delta_reg, delta_next;
    logic signed [49:0]  tmp_reg,   tmp_next;
    logic signed [65:0]  acc_reg,   acc_next;
    logic                dsign_reg, dsign_next;
    logic signed [47:0]  integ_reg, integ_next;
    logic signed [31:0]  prev_reg,  prev_next;
    logic [31:0]         drive_reg, drive_next;
    logic [1:0]          limit_reg, limit_next;
    logic                m_tvalid_reg, m_tvalid_next;

    logic signed [32:0]  mul_a;
    logic signed [32:0]  mul_b;
    logic signed [65:0]  prod;
    logic [65:0]         prod_neg;
    logic [63:0]         div_dividend;
    logic [31:0]         div_divisor;
    logic                div_busy;
    logic [63:0]         quo;
    logic [63:0]         quo_sat;

    logic signed [65:0]  p_term;
    logic signed [65:0]  integ_ext;
    logic signed [65:0]  d_pos;
    logic signed [65:0]  d_term;
    logic signed [65:0]  hi_ext;
    logic signed [65:0]  lo_ext;
    logic signed [47:0]  integ_sat;
    logic                above;
    logic                below;
    logic                in_accept;

    pcaw_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (status),
        .ctrl    (ctrl)
    );

    always_comb begin
        case (ctrl.mul_sel)
            MUL_ERR_KP: begin
                mul_a = err_reg;
                mul_b = {kp_reg[31], kp_reg};
            end
            MUL_ERR_KI: begin
                mul_a = err_reg;
                mul_b = {ki_reg[31], ki_reg};
            end
            MUL_KD_DELTA: begin
                mul_a = {kd_reg[31], kd_reg};
                mul_b = delta_reg;
            end
            MUL_F1HI_PER: begin
                mul_a = tmp_reg[48:16];
                mul_b = {1'b0, per_reg};
            end
            MUL_F1LO_PER: begin
                mul_a = {17'd0, tmp_reg[15:0]};
                mul_b = {1'b0, per_reg};
            end
            default: begin
                mul_a = err_reg;
                mul_b = {kp_reg[31], kp_reg};
            end
        endcase
    end

    pcaw_mul u_mul (
        .aclk (aclk),
        .en   (ctrl.mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .p    (prod)
    );

    assign prod_neg     = -prod;
    assign div_dividend = prod[65] ? prod_neg[63:0] : prod[63:0];
    assign div_divisor  = (per_reg == 32'd0) ? 32'd1 : per_reg;

    pcaw_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (ctrl.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quotient (quo)
    );

    // floor(x / 2^16) of the product
    assign p_term    = {{16{prod[65]}}, prod[65:16]};
    assign integ_ext = {{18{integ_reg[47]}}, integ_reg};
    assign hi_ext    = {{34{hi_reg[31]}}, hi_reg};
    assign lo_ext    = {{34{lo_reg[31]}}, lo_reg};
    assign above     = acc_reg > hi_ext;
    assign below     = acc_reg < lo_ext;

    // quotient limited to 2^62
    assign quo_sat = (quo[63] || (quo[62] && (|quo[61:0]))) ? {2'b01, 62'd0} : quo;
    assign d_pos   = {2'b00, quo_sat};
    assign d_term  = dsign_reg ? d_pos : -d_pos;

    always_comb begin
        if (!acc_reg[65] && (|acc_reg[64:47])) begin
            integ_sat = {1'b0, {47{1'b1}}};
        end else if (acc_reg[65] && !(&acc_reg[64:47])) begin
            integ_sat = {1'b1, 47'd0};
        end else begin
            integ_sat = acc_reg[47:0];
        end
    end

    assign in_accept       = s_tvalid && ctrl.in_ready;
    assign status.start    = s_tvalid;
    assign status.clear    = act_reg;
    assign status.div_busy = div_busy;
    assign status.out_busy = m_tvalid_reg && !m_tready;

    always_comb begin
        sp_next       = sp_reg;
        ms_next       = ms_reg;
        act_next      = act_reg;
        err_next      = err_reg;
        delta_next    = delta_reg;
        tmp_next      = tmp_reg;
        acc_next      = acc_reg;
        dsign_next    = dsign_reg;
        integ_next    = integ_reg;
        prev_next     = prev_reg;
        drive_next    = drive_reg;
        limit_next    = limit_reg;
        m_tvalid_next = m_tready ? 1'b0 : m_tvalid_reg;
        if (ctrl.div_start) begin
            dsign_next = prod[65];
        end
        case (ctrl.op)
            OP_CAPTURE: begin
                if (in_accept) begin
                    sp_next  = s_tdata[31:0];
                    ms_next  = s_tdata[63:32];
                    act_next = s_tuser;
                end
            end
            OP_DIFFS: begin
                err_next   = {sp_reg[31], sp_reg} - {ms_reg[31], ms_reg};
                delta_next = {ms_reg[31], ms_reg} - {prev_reg[31], prev_reg};
            end
            OP_TMP_FLOOR: begin
                tmp_next = prod[65:16];
            end
            OP_ACC_INTEG_PROD: begin
                acc_next = integ_ext + prod;
            end
            OP_ACC_ADD_PROD_SH: begin
                acc_next = acc_reg + p_term;
            end
            OP_INTEG_SAT: begin
                integ_next = integ_sat;
            end
            OP_ACC_P_INTEG: begin
                acc_next = p_term + integ_ext;
            end
            OP_ACC_ADD_DERIV: begin
                acc_next = acc_reg + d_term;
            end
            OP_FINISH: begin
                m_tvalid_next = 1'b1;
                prev_next     = ms_reg;
                if (above) begin
                    drive_next = hi_reg;
                    limit_next = LIMIT_HIGH;
                    integ_next = '0;
                end else if (below) begin
                    drive_next = lo_reg;
                    limit_next = LIMIT_LOW;
                    integ_next = '0;
                end else begin
                    drive_next = acc_reg[31:0];
                    limit_next = LIMIT_NONE;
                end
            end
            OP_CLEAR: begin
                integ_next = '0;
                prev_next  = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kp_reg       <= '0;
            ki_reg       <= '0;
            kd_reg       <= '0;
            lo_reg       <= LO_BOUND_RST;
            hi_reg       <= HI_BOUND_RST;
            per_reg      <= PERIOD_RST;
            integ_reg    <= '0;
            prev_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            integ_reg    <= integ_next;
            prev_reg     <= prev_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_we) begin
                case (cfg_index)
                    REG_KP:  kp_reg  <= cfg_wdata;
                    REG_KI:  ki_reg  <= cfg_wdata;
                    REG_KD:  kd_reg  <= cfg_wdata;
                    REG_LO:  lo_reg  <= cfg_wdata;
                    REG_HI:  hi_reg  <= cfg_wdata;
                    REG_PER: per_reg <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        sp_reg    <= sp_next;
        ms_reg    <= ms_next;
        act_reg   <= act_next;
        err_reg   <= err_next;
        delta_reg <= delta_next;
        tmp_reg   <= tmp_next;
        acc_reg   <= acc_next;
        dsign_reg <= dsign_next;
        drive_reg <= drive_next;
        limit_reg <= limit_next;
    end

    assign s_tready = ctrl.in_ready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = drive_reg;
    assign m_tuser  = limit_reg;

endmodule

// ===== rtl/pcaw_checker.sv =====
// ----------------------------------------------------------------------------
// PID controller port checker
// Port-level properties of the controller, attached by bind.
// ----------------------------------------------------------------------------
`include "pid_controller_anti_windup_unit_defines.svh"

module pcaw_checker
    import pcaw_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [31:0]           m_tdata,
    input  logic [1:0]            m_tuser
);

    `PCAW_ASSERT_SAME(a_limit_code, m_tvalid, (m_tuser == LIMIT_NONE) || (m_tuser == LIMIT_HIGH) || (m_tuser == LIMIT_LOW), "limit_hit code out of range")

    `PCAW_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready, "request accepted while another is in progress")

    `PCAW_ASSERT_NEXT(a_no_instant_result, s_tvalid && s_tready, !$rose(m_tvalid), "result raised right after accept")

    `PCAW_ASSERT_NEXT(a_valid_hold, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")

    `PCAW_ASSERT_NEXT(a_payload_hold, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

endmodule

bind pid_controller_anti_windup_unit pcaw_checker u_pcaw_checker (.*);

// ===== dv/tb_pid_controller_anti_windup_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PID controller with anti-windup testbench
// Drives update and clear requests with random idle on both streams, loads
// gains, bounds and sample period between phases, and compares every drive
// and clamp code against a Q16.16 model of the controller step.
// ----------------------------------------------------------------------------
module tb_pid_controller_anti_windup_unit
    import pcaw_pkg::*;
();

    typedef logic signed [127:0] wide_t;

    typedef struct packed {
        logic [31:0] drive;
        logic [1:0]  limit;
    } drive_result_t;

    typedef enum int {STYLE_TAME, STYLE_WILD, STYLE_EDGE} setting_style_t;

    localparam logic ACT_UPDATE = 1'b0;
    localparam logic ACT_CLEAR  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    localparam wide_t SAT62     = wide_t'(1) <<< 62;
    localparam wide_t INTEG_MAX = (wide_t'(1) <<< 47) - 1;
    localparam wide_t INTEG_MIN = -(wide_t'(1) <<< 47);

    localparam logic [31:0] EDGE_VALS [4] = '{32'h8000_0000, 32'h7FFF_FFFF,
                                              32'h0000_0000, 32'hFFFF_FFFF};

    localparam int SETTLE         = 60;
    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int NUM_PHASES     = 14;
    localparam int PHASE_ITEMS    = 75;

    class drive_scoreboard;
        logic [31:0]        kp, ki, kd, lo_bound, hi_bound, period;
        logic signed [47:0] integ;
        logic signed [31:0] prev_ms;
        drive_result_t      expected_drive[$];
        int                 errors;

        function new();
            kp       = '0;
            ki       = '0;
            kd       = '0;
            lo_bound = LO_BOUND_RST;
            hi_bound = HI_BOUND_RST;
            period   = PERIOD_RST;
            integ    = '0;
            prev_ms  = '0;
            errors   = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
            case (idx)
                REG_KP:  kp       = val;
                REG_KI:  ki       = val;
                REG_KD:  kd       = val;
                REG_LO:  lo_bound = val;
                REG_HI:  hi_bound = val;
                REG_PER: period   = val;
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_drive.size();
        endfunction

        // one controller step for an accepted request
        function void note_request(logic act, logic signed [31:0] sp,
                                   logic signed [31:0] ms);
            wide_t         err, per_w, frac, inc, acc, delta, prod, mg, quo, deriv, sum;
            drive_result_t r;
            if (act == ACT_CLEAR) begin
                integ   = '0;
                prev_ms = '0;
                return;
            end
            per_w = wide_t'(period);
            err   = wide_t'(sp) - wide_t'(ms);

            frac = (err * wide_t'($signed(ki))) >>> 16;
            inc  = (frac * per_w) >>> 16;
            if (inc > SAT62)
                inc = SAT62;
            else if (inc < -SAT62)
                inc = -SAT62;
            acc = wide_t'(integ) + inc;
            if (acc > INTEG_MAX)
                acc = INTEG_MAX;
            else if (acc < INTEG_MIN)
                acc = INTEG_MIN;
            integ = acc[47:0];

            // derivative on measurement, quotient truncated toward zero
            delta = wide_t'(ms) - wide_t'(prev_ms);
            prod  = wide_t'($signed(kd)) * delta;
            mg    = (prod < 0) ? -prod : prod;
            quo   = mg / ((period == '0) ? wide_t'(1) : per_w);
            if (quo > SAT62)
                quo = SAT62;
            deriv = (prod < 0) ? quo : -quo;

            sum     = ((err * wide_t'($signed(kp))) >>> 16) + wide_t'(integ) + deriv;
            r.limit = LIMIT_NONE;
            if (sum > wide_t'($signed(hi_bound))) begin
                sum     = wide_t'($signed(hi_bound));
                integ   = '0;
                r.limit = LIMIT_HIGH;
            end else if (sum < wide_t'($signed(lo_bound))) begin
                sum     = wide_t'($signed(lo_bound));
                integ   = '0;
                r.limit = LIMIT_LOW;
            end
            prev_ms = ms;
            r.drive = sum[31:0];
            expected_drive.push_back(r);
        endfunction

        function void check_drive(logic [31:0] drive, logic [1:0] limit);
            drive_result_t exp_r;
            if (expected_drive.size() == 0) begin
                errors++;
                $display("%0t: unexpected result: expected none, actual drive %h limit %0d",
                         $time, drive, limit);
                return;
            end
            exp_r = expected_drive.pop_front();
            if (drive !== exp_r.drive) begin
                errors++;
                $display("%0t: drive mismatch: expected %h, actual %h",
                         $time, exp_r.drive, drive);
            end
            if (limit !== exp_r.limit) begin
                errors++;
                $display("%0t: limit_hit mismatch: expected %0d, actual %0d",
                         $time, exp_r.limit, limit);
            end
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [63:0]          s_tdata   = '0;   // [31:0] setpoint, [63:32] measurement
    logic                 s_tuser   = 1'b0; // [0] action
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [31:0]          m_tdata;          // [31:0] drive
    logic [1:0]           m_tuser;          // [1:0] limit_hit
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]          cfg_wdata = '0;

    drive_scoreboard    sb;
    bit                 gaps_on   = 1'b1;
    int                 rx_hold   = 0;
    logic signed [31:0] target_sp = '0;
    logic signed [31:0] walk_ms   = '0;

    pid_controller_anti_windup_unit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    task automatic send_request(input logic act, input logic [31:0] sp,
                                input logic [31:0] ms);
        int gap;
        gap = gaps_on ? $urandom_range(0, 15) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {ms, sp};
        s_tuser  <= act;
        do @(posedge aclk); while (!s_tready);
        sb.note_request(act, sp, ms);
    endtask

    // stop offering, let every result drain, then let the sequencer settle
    task automatic wait_idle(input int settle);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (settle) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        sb.write_reg(idx, val);
    endtask

    task automatic apply_settings(input logic [31:0] kp, input logic [31:0] ki,
                                  input logic [31:0] kd, input logic [31:0] lo,
                                  input logic [31:0] hi, input logic [31:0] per);
        wait_idle(SETTLE);
        write_reg(REG_SPARE_LO, $urandom);
        write_reg(REG_KP, kp);
        write_reg(REG_KI, ki);
        write_reg(REG_KD, kd);
        write_reg(REG_LO, lo);
        write_reg(REG_HI, hi);
        write_reg(REG_PER, per);
        write_reg(REG_SPARE_HI, $urandom);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] tame_gain(input int unsigned span);
        logic [31:0] g;
        g = $urandom_range(0, span);
        return ($urandom_range(0, 3) == 0) ? -g : g;
    endfunction

    // mostly a measurement that tracks the setpoint, plus noise and extremes
    task automatic pick_item(output logic act, output logic [31:0] sp,
                             output logic [31:0] ms);
        int unsigned r;
        longint      m;
        act = ($urandom_range(0, 99) < 4) ? ACT_CLEAR : ACT_UPDATE;
        r   = $urandom_range(0, 99);
        if (r < 60) begin
            m = longint'(walk_ms) + (longint'(target_sp) - longint'(walk_ms)) / 8
                + longint'($urandom_range(0, 4095)) - 2048;
            if (m > 64'sd2147483647)
                m = 64'sd2147483647;
            else if (m < -64'sd2147483648)
                m = -64'sd2147483648;
            walk_ms = m[31:0];
            sp      = target_sp;
            ms      = walk_ms;
        end else if (r < 80) begin
            sp = $urandom;
            ms = $urandom;
        end else if (r < 90) begin
            sp = EDGE_VALS[$urandom_range(0, 3)];
            ms = EDGE_VALS[$urandom_range(0, 3)];
        end else begin
            sp = $urandom_range(0, 511) - 256;
            ms = $urandom_range(0, 511) - 256;
        end
    endtask

    initial begin : result_sink
        int stall;
        wait (aresetn === 1'b1);
        forever begin
            stall = gaps_on ? $urandom_range(0, 15) : 0;
            if (rx_hold > 0) begin
                stall   = rx_hold;
                rx_hold = 0;
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            sb.check_drive(m_tdata, m_tuser);
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin : stimulus
        logic           act;
        logic [31:0]    sp, ms, kp, ki, kd, lo, hi, per;
        setting_style_t style;
        sb = new();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // register defaults
        send_request(ACT_UPDATE, 32'h0003_0000, 32'h0001_0000);
        send_request(ACT_UPDATE, 32'h7FFF_FFFF, 32'h8000_0000);

        // moderate gains, +-1000.0 bounds
        apply_settings(32'h0001_0000, 32'h0000_8000, 32'h0000_4000,
                       32'hFC18_0000, 32'h03E8_0000, 32'h0001_0000);
        send_request(ACT_UPDATE, 32'h000A_0000, 32'h0000_0000);
        send_request(ACT_UPDATE, 32'h000A_0000, 32'h0002_0000);
        send_request(ACT_UPDATE, 32'h7FFF_FFFF, 32'h8000_0000);
        send_request(ACT_UPDATE, 32'h8000_0000, 32'h7FFF_FFFF);
        send_request(ACT_CLEAR,  32'h0000_0000, 32'h0000_0000);
        send_request(ACT_UPDATE, 32'h0000_0000, 32'h0000_0000);
        send_request(ACT_UPDATE, 32'hFFFF_FFFF, 32'h0000_0001);

        // full-scale gains, zero sample period
        apply_settings(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                       32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000);
        send_request(ACT_UPDATE, 32'h7FFF_FFFF, 32'h8000_0000);
        send_request(ACT_UPDATE, 32'h8000_0000, 32'h7FFF_FFFF);
        send_request(ACT_UPDATE, 32'hFFFF_FFFF, 32'h0000_0000);
        send_request(ACT_CLEAR,  32'h1234_5678, 32'h8765_4321);
        send_request(ACT_UPDATE, 32'h7FFF_FFFF, 32'h7FFF_FFFF);

        // crossed bounds, largest period
        apply_settings(32'hFFFF_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                       32'h0064_0000, 32'hFF9C_0000, 32'hFFFF_FFFF);
        send_request(ACT_UPDATE, 32'h0000_0000, 32'h0000_0000);
        send_request(ACT_UPDATE, 32'h0032_0000, 32'h0000_0000);
        send_request(ACT_UPDATE, 32'h8000_0000, 32'h7FFF_FFFF);
        send_request(ACT_UPDATE, 32'h7FFF_FFFF, 32'h8000_0000);

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            if (phase == 2 || phase == 12)
                style = STYLE_EDGE;
            else if (phase == 5 || phase == 9)
                style = STYLE_WILD;
            else
                style = STYLE_TAME;
            case (style)
                STYLE_WILD: begin
                    kp  = $urandom;
                    ki  = $urandom;
                    kd  = $urandom;
                    lo  = $urandom;
                    hi  = $urandom;
                    per = $urandom;
                end
                STYLE_EDGE: begin
                    kp  = EDGE_VALS[$urandom_range(0, 3)];
                    ki  = EDGE_VALS[$urandom_range(0, 3)];
                    kd  = EDGE_VALS[$urandom_range(0, 3)];
                    lo  = EDGE_VALS[$urandom_range(0, 1)];
                    hi  = EDGE_VALS[$urandom_range(0, 1)];
                    per = (phase == 2) ? 32'h0000_0001 : 32'hFFFF_FFFF;
                end
                default: begin
                    kp  = tame_gain(32'h0004_0000);
                    ki  = tame_gain(32'h0001_0000);
                    kd  = tame_gain(32'h0000_8000);
                    lo  = -$urandom_range(32'h0100_0000, 32'h07D0_0000);
                    hi  = $urandom_range(32'h0100_0000, 32'h07D0_0000);
                    per = $urandom_range(0, 1) ? 32'h0001_0000
                                               : $urandom_range(32'h100, 32'h4_0000);
                end
            endcase
            apply_settings(kp, ki, kd, lo, hi, per);
            gaps_on   = (phase % 3 != 1);
            target_sp = $urandom_range(0, 32'h03E8_0000) - 32'h01F4_0000;
            walk_ms   = target_sp + $urandom_range(0, 32'h0064_0000) - 32'h0032_0000;
            if (phase == 3)
                rx_hold = LONG_HOLD;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (phase == 6 && n == 40)
                    wait_idle(1);
                if (n % 25 == 24)
                    target_sp = $urandom_range(0, 32'h03E8_0000) - 32'h01F4_0000;
                pick_item(act, sp, ms);
                send_request(act, sp, ms);
            end
        end

        wait_idle(SETTLE);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
